// File: hw/rtl/pbrle_pkg.sv
// Shared constants and types of the PackBits run-length encoder.
// Used by pbrle_front, pbrle_cmd_fifo, pbrle_back and the top level.
// No dependencies.
package pbrle_pkg;

  localparam int unsigned MaxLiteralDefault = 32;
  localparam int unsigned MaxRunDefault     = 128;
  localparam int unsigned StoreDepth        = 32;
  localparam int unsigned StoreAw           = $clog2(StoreDepth);
  localparam int unsigned CountW            = $clog2(StoreDepth + 1);
  localparam int unsigned QueueDepth        = 4;

  localparam logic [7:0] EndMarker = 8'd128;

  localparam logic [1:0] CMD_LIT = 2'd0;
  localparam logic [1:0] CMD_RUN = 2'd1;
  localparam logic [1:0] CMD_END = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [7:0] len;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: hw/rtl/pbrle_front.sv
// Front end: accepts raw bytes, tracks the open group and issues commands.
// Depends on pbrle_pkg.
module pbrle_front #(
  parameter int unsigned RUN_LIMIT = pbrle_pkg::MaxRunDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_stream_i,
  output logic              push_o,
  output pbrle_pkg::cmd_t   cmd_o,
  input  pbrle_pkg::q_status_t q_status_i
);

  localparam logic [1:0] PH_ITEM  = 2'd0;
  localparam logic [1:0] PH_CLOSE = 2'd1;
  localparam logic [1:0] PH_END   = 2'd2;

  logic       cur_vld_q;
  logic [7:0] cur_byte_q;
  logic       cur_last_q;
  logic [1:0] phase_q;
  logic [7:0] held_q;
  logic [7:0] rc_q;

  logic            extend;
  logic            need_push;
  logic            step;
  logic            done_item;
  logic            accept;
  pbrle_pkg::cmd_t close_cmd;

  assign extend = (rc_q != 8'd0) && (cur_byte_q == held_q) && (rc_q < 8'(RUN_LIMIT));

  always_comb begin
    close_cmd.kind  = (rc_q == 8'd1) ? pbrle_pkg::CMD_LIT : pbrle_pkg::CMD_RUN;
    close_cmd.value = held_q;
    close_cmd.len   = rc_q;
    cmd_o     = close_cmd;
    need_push = 1'b0;
    case (phase_q)
      PH_ITEM: begin
        need_push = !extend && (rc_q != 8'd0);
      end
      PH_CLOSE: begin
        need_push = 1'b1;
      end
      PH_END: begin
        need_push = 1'b1;
        cmd_o.kind  = pbrle_pkg::CMD_END;
        cmd_o.value = pbrle_pkg::EndMarker;
        cmd_o.len   = 8'd0;
      end
      default: begin
        need_push = 1'b0;
      end
    endcase
  end

  assign step      = cur_vld_q && (!need_push || !q_status_i.full);
  assign push_o    = cur_vld_q && need_push && !q_status_i.full;
  assign done_item = step && ((phase_q == PH_END) || ((phase_q == PH_ITEM) && !cur_last_q));
  assign in_stall_o = cur_vld_q && !done_item;
  assign accept    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      phase_q   <= PH_ITEM;
      held_q    <= 8'd0;
      rc_q      <= 8'd0;
    end else begin
      if (step) begin
        case (phase_q)
          PH_ITEM: begin
            if (extend) begin
              rc_q <= rc_q + 8'd1;
            end else begin
              held_q <= cur_byte_q;
              rc_q   <= 8'd1;
            end
            if (cur_last_q) begin
              phase_q <= PH_CLOSE;
            end
          end
          PH_CLOSE: begin
            phase_q <= PH_END;
          end
          PH_END: begin
            held_q <= 8'd0;
            rc_q   <= 8'd0;
          end
          default: begin
            phase_q <= PH_ITEM;
          end
        endcase
      end
      if (done_item) begin
        cur_vld_q <= 1'b0;
      end
      if (accept) begin
        cur_vld_q <= 1'b1;
        phase_q   <= PH_ITEM;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_byte_q <= data_byte_i;
      cur_last_q <= end_of_stream_i;
    end
  end

  a_rc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rc_q <= 8'(RUN_LIMIT))
    else $error("group length beyond run limit");

endmodule

// File: hw/rtl/pbrle_cmd_fifo.sv
// Command queue between front and back ends of the encoder.
// Depends on pbrle_pkg.
module pbrle_cmd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  pbrle_pkg::cmd_t      push_cmd_i,
  input  logic                 pop_i,
  output pbrle_pkg::cmd_t      head_o,
  output pbrle_pkg::q_status_t status_o
);

  localparam int unsigned PtrW = $clog2(pbrle_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(pbrle_pkg::QueueDepth + 1);

  pbrle_pkg::cmd_t mem_q [pbrle_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push;
  logic            do_pop;

  assign status_o.full  = (cnt_q == CntW'(pbrle_pkg::QueueDepth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= PtrW'((32'(wr_ptr_q) + 32'd1) % pbrle_pkg::QueueDepth);
      end
      if (do_pop) begin
        rd_ptr_q <= PtrW'((32'(rd_ptr_q) + 32'd1) % pbrle_pkg::QueueDepth);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.full |-> !push_i)
    else $error("push into full command queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.empty |-> !pop_i)
    else $error("pop from empty command queue");

endmodule

// File: hw/rtl/pbrle_back.sv
// Back end: executes commands, holds the literal store, drives the code register.
// Depends on pbrle_pkg.
module pbrle_back #(
  parameter int unsigned LIT_LIMIT = pbrle_pkg::MaxLiteralDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pbrle_pkg::cmd_t      head_i,
  input  pbrle_pkg::q_status_t q_status_i,
  output logic                 pop_o,
  output logic                 code_valid_o,
  input  logic                 code_stall_i,
  output logic [7:0]           code_byte_o,
  output logic                 code_last_o
);

  localparam int unsigned CW = pbrle_pkg::CountW;
  localparam int unsigned AW = pbrle_pkg::StoreAw;

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_FL_HDR   = 2'd1;
  localparam logic [1:0] ST_FL_DATA  = 2'd2;
  localparam logic [1:0] ST_RUN_BYTE = 2'd3;

  logic [7:0]    store_q [pbrle_pkg::StoreDepth];
  logic [1:0]    state_q, state_d;
  logic [CW-1:0] lcnt_q, lcnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [7:0]    rd_data_q;
  logic [7:0]    run_byte_q;
  logic          out_vld_q;
  logic [7:0]    out_byte_q;
  logic          out_last_q;

  logic          can_load;
  logic          load;
  logic [7:0]    load_byte;
  logic          load_last;
  logic          wr_en;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          take_run;

  assign can_load = !out_vld_q || !code_stall_i;

  always_comb begin
    state_d   = state_q;
    lcnt_d    = lcnt_q;
    idx_d     = idx_q;
    pop_o     = 1'b0;
    load      = 1'b0;
    load_byte = 8'd0;
    load_last = 1'b0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    take_run  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!q_status_i.empty) begin
          case (head_i.kind)
            pbrle_pkg::CMD_LIT: begin
              pop_o  = 1'b1;
              wr_en  = 1'b1;
              lcnt_d = lcnt_q + CW'(1);
              if (lcnt_d == CW'(LIT_LIMIT)) begin
                state_d = ST_FL_HDR;
              end
            end
            pbrle_pkg::CMD_RUN: begin
              if (lcnt_q != '0) begin
                state_d = ST_FL_HDR;
              end else if (can_load) begin
                pop_o     = 1'b1;
                load      = 1'b1;
                load_byte = 8'd1 - head_i.len;
                take_run  = 1'b1;
                state_d   = ST_RUN_BYTE;
              end
            end
            pbrle_pkg::CMD_END: begin
              if (lcnt_q != '0) begin
                state_d = ST_FL_HDR;
              end else if (can_load) begin
                pop_o     = 1'b1;
                load      = 1'b1;
                load_byte = pbrle_pkg::EndMarker;
                load_last = 1'b1;
              end
            end
            default: begin
              pop_o = 1'b1;
            end
          endcase
        end
      end
      ST_FL_HDR: begin
        if (can_load) begin
          load      = 1'b1;
          load_byte = 8'({2'b00, lcnt_q - CW'(1)});
          rd_en     = 1'b1;
          rd_addr   = '0;
          idx_d     = CW'(1);
          state_d   = ST_FL_DATA;
        end
      end
      ST_FL_DATA: begin
        if (can_load) begin
          load      = 1'b1;
          load_byte = rd_data_q;
          if (idx_q == lcnt_q) begin
            lcnt_d  = '0;
            state_d = ST_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_q[AW-1:0];
            idx_d   = idx_q + CW'(1);
          end
        end
      end
      ST_RUN_BYTE: begin
        if (can_load) begin
          load      = 1'b1;
          load_byte = run_byte_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      lcnt_q    <= '0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      lcnt_q  <= lcnt_d;
      idx_q   <= idx_d;
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (!code_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= load_byte;
      out_last_q <= load_last;
    end
    if (take_run) begin
      run_byte_q <= head_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[lcnt_q[AW-1:0]] <= head_i.value;
    end
    if (rd_en) begin
      rd_data_q <= store_q[rd_addr];
    end
  end

  assign code_valid_o = out_vld_q;
  assign code_byte_o  = out_byte_q;
  assign code_last_o  = out_last_q;

  a_lcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (lcnt_q < CW'(LIT_LIMIT)))
    else $error("literal count at limit while idle");

  a_last_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_last_q) |-> (out_byte_q == pbrle_pkg::EndMarker))
    else $error("last beat is not the end marker");

endmodule

// File: hw/rtl/packbits_run_length_encoder.sv
// PackBits run-length encoder, top level.
// Depends on pbrle_pkg, pbrle_front, pbrle_cmd_fifo and pbrle_back.
//
// Input channel: one raw byte per beat (data_byte_i, end_of_stream_i on the
// final byte), accepted when in_valid_i is high and in_stall_o is low.
// Output channel: one code byte per beat (code_byte_o, code_last_o), taken
// when code_valid_o is high and code_stall_i is low. code_last_o marks the
// end marker 128 that closes each stream.
// A byte that extends a run queues no command, so runs stream at one input
// beat per cycle. A byte that closes a group queues one command; the back
// end stores a literal and emits a flush of N literals as N+1 output beats
// and a run as two, one output beat per cycle while code_stall_i is low.
// Code bytes leave through the single output register.
// The end-of-stream byte passes three front-end steps (group update, close,
// end marker) before the next stream may begin.
// Reset clears all control state; no beat is pending afterwards.
// While code_stall_i is high the output beat holds, the command queue fills
// and in_stall_o rises once the front end cannot queue a command.
module packbits_run_length_encoder #(
  parameter int unsigned MAX_LITERAL = pbrle_pkg::MaxLiteralDefault,
  parameter int unsigned MAX_RUN     = pbrle_pkg::MaxRunDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_stream_i,
  output logic       code_valid_o,
  input  logic       code_stall_i,
  output logic [7:0] code_byte_o,
  output logic       code_last_o
);

  localparam int unsigned LitLimit =
    (MAX_LITERAL > pbrle_pkg::StoreDepth) ? pbrle_pkg::StoreDepth :
    ((MAX_LITERAL < 1) ? 1 : MAX_LITERAL);
  localparam int unsigned RunLimit =
    (MAX_RUN < 2) ? 2 : ((MAX_RUN > 128) ? 128 : MAX_RUN);

  logic                 push;
  pbrle_pkg::cmd_t      push_cmd;
  logic                 pop;
  pbrle_pkg::cmd_t      head;
  pbrle_pkg::q_status_t q_status;

  pbrle_front #(
    .RUN_LIMIT (RunLimit)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .push_o          (push),
    .cmd_o           (push_cmd),
    .q_status_i      (q_status)
  );

  pbrle_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .status_o   (q_status)
  );

  pbrle_back #(
    .LIT_LIMIT (LitLimit)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .code_valid_o (code_valid_o),
    .code_stall_i (code_stall_i),
    .code_byte_o  (code_byte_o),
    .code_last_o  (code_last_o)
  );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for packbits_run_length_encoder: drives byte streams,
// predicts each code beat in-line and compares every beat on the output channel.
// Depends on pbrle_pkg and the encoder RTL only.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned LitLimit =
      (pbrle_pkg::MaxLiteralDefault > pbrle_pkg::StoreDepth) ? pbrle_pkg::StoreDepth :
      (pbrle_pkg::MaxLiteralDefault < 1) ? 1 : pbrle_pkg::MaxLiteralDefault;
  localparam int unsigned RunLimit =
      (pbrle_pkg::MaxRunDefault < 2) ? 2 :
      (pbrle_pkg::MaxRunDefault > 128) ? 128 : pbrle_pkg::MaxRunDefault;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } code_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] data_byte_i = 8'd0;
  logic       end_of_stream_i = 1'b0;
  logic       code_valid_o;
  logic       code_stall_i = 1'b0;
  logic [7:0] code_byte_o;
  logic       code_last_o;

  code_beat_t  pending_codes[$];
  logic [7:0]  lit_buf [pbrle_pkg::StoreDepth];
  int unsigned lit_cnt;
  logic [7:0]  held_val;
  int unsigned run_len;

  bit          send_idle_on;
  bit          stall_idle_on;
  int unsigned n_errors;
  int unsigned n_streams;
  int unsigned n_bytes_in;
  int unsigned n_codes_seen;

  packbits_run_length_encoder i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .code_valid_o    (code_valid_o),
    .code_stall_i    (code_stall_i),
    .code_byte_o     (code_byte_o),
    .code_last_o     (code_last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic void push_code(input logic [7:0] value, input logic last);
    code_beat_t beat;
    beat.value = value;
    beat.last  = last;
    pending_codes.insert(pending_codes.size(), beat);
  endfunction

  function automatic void flush_literals();
    if (lit_cnt == 0) return;
    push_code(8'(lit_cnt - 1), 1'b0);
    for (int unsigned i = 0; i < lit_cnt; i++) push_code(lit_buf[i], 1'b0);
    lit_cnt = 0;
  endfunction

  function automatic void close_group();
    if (run_len >= 2) begin
      flush_literals();
      push_code(8'(257 - run_len), 1'b0);
      push_code(held_val, 1'b0);
    end else if (run_len == 1) begin
      lit_buf[lit_cnt] = held_val;
      lit_cnt++;
      if (lit_cnt >= LitLimit) flush_literals();
    end
    run_len = 0;
  endfunction

  function automatic void encode_byte(input logic [7:0] b, input logic eos);
    if (run_len != 0 && b == held_val && run_len < RunLimit) begin
      run_len++;
    end else begin
      close_group();
      held_val = b;
      run_len  = 1;
    end
    if (eos) begin
      close_group();
      flush_literals();
      push_code(pbrle_pkg::EndMarker, 1'b1);
      lit_cnt  = 0;
      held_val = 8'd0;
      run_len  = 0;
    end
  endfunction

  // check every code beat against the oldest prediction
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && code_valid_o && !code_stall_i) begin
        n_codes_seen++;
        if (pending_codes.size() == 0) begin
          $error("unexpected code beat: code_byte %0d code_last %0b", code_byte_o, code_last_o);
          n_errors++;
        end else begin
          code_beat_t exp_beat;
          exp_beat = pending_codes[0];
          pending_codes.delete(0);
          if (code_byte_o !== exp_beat.value) begin
            $error("code_byte: expected %0d, actual %0d", exp_beat.value, code_byte_o);
            n_errors++;
          end
          if (code_last_o !== exp_beat.last) begin
            $error("code_last: expected %0b, actual %0b", exp_beat.last, code_last_o);
            n_errors++;
          end
        end
      end
    end
  end

  // output stall bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_idle_on && $urandom_range(0, 5) == 0) begin
        code_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        code_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eos);
    if (send_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    end_of_stream_i <= eos;
    do @(posedge clk_i); while (in_stall_o);
    encode_byte(b, eos);
    n_bytes_in++;
    if (eos) n_streams++;
  endtask

  task automatic drain_codes();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_codes.size() != 0);
  endtask

  task automatic test_short_streams();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h12, 1'b1);
  endtask

  task automatic test_run_limit();
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    for (int i = 0; i < RunLimit + 2; i++) send_byte(v, 1'b0);
    send_byte(~v, 1'b1);
  endtask

  task automatic test_literal_limit();
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    for (int i = 0; i < LitLimit + 2; i++) begin
      send_byte(v, 1'b0);
      v = v + 8'($urandom_range(1, 255));
    end
    send_byte(v, 1'b1);
  endtask

  task automatic test_random_streams(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    logic [7:0]  v;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 140) : $urandom_range(1, 30);
      if (len > n_items - sent) len = n_items - sent;
      v = 8'($urandom_range(0, 255));
      for (int unsigned i = 0; i < len; i++) begin
        case ($urandom_range(0, 3))
          0: v = 8'($urandom_range(0, 255));
          1: v = 8'($urandom_range(0, 3));
          default: ;
        endcase
        send_byte(v, i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    lit_cnt       = 0;
    held_val      = 8'd0;
    run_len       = 0;
    send_idle_on  = 1'b1;
    stall_idle_on = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_short_streams();
    test_run_limit();
    drain_codes();
    test_literal_limit();
    test_random_streams(50);
    send_idle_on  = 1'b0;
    stall_idle_on = 1'b0;
    test_random_streams(20);

    drain_codes();
    repeat (20) @(posedge clk_i);
    $display("covered %0d streams, %0d input bytes, %0d code beats checked",
             n_streams, n_bytes_in, n_codes_seen);
    $display("runs up to the limit, literal buffer flushes, run after literals, lone bytes");
    if (n_errors == 0 && pending_codes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
